// ----- hdl/gpio_edge_event_capture_fifo_macros.svh -----
// Assertion macros used by the capture FIFO top level.
`ifndef GPIO_EDGE_EVENT_CAPTURE_FIFO_MACROS_SVH
`define GPIO_EDGE_EVENT_CAPTURE_FIFO_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GEEC_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("geec: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GEEC_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("geec: next-cycle check failed");

`endif

// ----- hdl/geec_pkg.sv -----
// Types and constants of the GPIO edge event capture FIFO.
package geec_pkg;

    localparam int MAX_LINES = 4;
    localparam int PIN_COUNT = 16;
    localparam int PIN_W     = 4;
    localparam int ID_W      = 8;
    localparam int TRIG_W    = 2;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 3;

    localparam logic [1:0] FUNC_EVENT  = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_ENABLE = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_NOT_CONFIG = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic [TRIG_W-1:0] TRIG_RISING  = 2'd0;
    localparam logic [TRIG_W-1:0] TRIG_FALLING = 2'd1;

    localparam logic [1:0] CFG_LINE_PINS     = 2'd0;
    localparam logic [1:0] CFG_LINE_IDS      = 2'd1;
    localparam logic [1:0] CFG_LINE_TRIGGERS = 2'd2;
    localparam logic [1:0] CFG_LINE_COUNT    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_READ
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   line_id;
        logic              rise;
        logic              level;
        logic [TIME_W-1:0] stamp;
    } sample_t;

    typedef struct packed {
        logic hit;
        logic rise;
        logic level;
        logic id_hit;
    } lane_res_t;

endpackage

// ----- hdl/geec_lane.sv -----
// One line lane: pin match, edge choice and id match for a single line.
module geec_lane (
    input  logic [geec_pkg::PIN_W-1:0]     pin,
    input  logic [geec_pkg::ID_W-1:0]      line_id,
    input  logic [geec_pkg::TRIG_W-1:0]    trig,
    input  logic                           armed,
    input  logic                           in_use,
    input  logic [geec_pkg::PIN_COUNT-1:0] pin_pending,
    input  logic [geec_pkg::PIN_COUNT-1:0] pin_levels,
    input  logic [geec_pkg::ID_W-1:0]      target_line,
    output geec_pkg::lane_res_t            res
);
    import geec_pkg::*;

    logic pin_ok;
    logic lvl;

    assign pin_ok = int'(pin) < PIN_COUNT;
    assign lvl    = pin_levels[pin];

    always_comb
    begin
        res.hit    = in_use && armed && pin_ok && pin_pending[pin];
        res.level  = lvl;
        res.id_hit = in_use && (line_id == target_line);
        case (trig)
            TRIG_RISING:  res.rise = 1'b1;
            TRIG_FALLING: res.rise = 1'b0;
            default:      res.rise = lvl;
        endcase
    end

endmodule

// ----- hdl/geec_ring.sv -----
// Sample ring storage: one write port, one registered read port.
module geec_ring #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  geec_pkg::sample_t        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output geec_pkg::sample_t        rdata
);
    import geec_pkg::*;

    sample_t mem [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/gpio_edge_event_capture_fifo.sv -----
// Top level of the GPIO edge event capture FIFO: lanes, merge sequencer and ring.
//
// Commands enter on start/func and the payload ports; a command is taken at a
// rising edge with start high and busy low. Each command gives one result word,
// shown for one cycle with done high; the receiver cannot stall it.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user must
// write it only while idle, the block itself does not enforce it.
// Processing: for an event the four lanes judge every line at once, then the
// merge pushes one sample a cycle through the single ring write port, one for
// each armed line with a pending pin (0..4). A pop that returns a sample goes
// through the registered ring read; every other command is answered from idle.
// A new command may be taken in the done cycle. dropped_total and
// ring_not_empty show the state after the command during done.
// Reset clears configuration, ring indices, drop counter and armed bits; no
// clearing pass runs, ring entries are only read after being written.
`include "gpio_edge_event_capture_fifo_macros.svh"

module gpio_edge_event_capture_fifo #(
    parameter int RING_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [15:0] pin_pending,
    input  logic [15:0] pin_levels,
    input  logic [31:0] event_time,
    input  logic [7:0]  target_line,
    input  logic        arm_flag,
    output logic        done,
    output logic [1:0]  op_status,
    output logic [7:0]  out_line_id,
    output logic        out_edge,
    output logic        out_level,
    output logic [31:0] out_time,
    output logic [2:0]  pushed_count,
    output logic [31:0] dropped_total,
    output logic        ring_not_empty,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import geec_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int IW   = $clog2(2 * RING_DEPTH);
    localparam int LAST = 2 * RING_DEPTH - 1;

    function automatic logic [AW-1:0] slot_of(input logic [IW-1:0] idx);
        slot_of = (idx >= IW'(RING_DEPTH)) ? AW'(idx - IW'(RING_DEPTH)) : AW'(idx);
    endfunction

    function automatic logic [IW-1:0] step_idx(input logic [IW-1:0] idx);
        step_idx = (idx == IW'(LAST)) ? '0 : idx + IW'(1);
    endfunction

    // configuration
    logic [MAX_LINES*PIN_W-1:0]  line_pins_reg;
    logic [MAX_LINES*ID_W-1:0]   line_ids_reg;
    logic [MAX_LINES*TRIG_W-1:0] line_triggers_reg;
    logic [CNT_W-1:0]            line_count_reg;

    // control state
    state_t                 state_reg, state_next;
    logic [IW-1:0]          w_reg, w_next;
    logic [IW-1:0]          r_reg, r_next;
    logic [31:0]            drop_reg, drop_next;
    logic [MAX_LINES-1:0]   armed_reg, armed_next;
    logic                   done_reg, done_next;

    // payload
    logic [MAX_LINES-1:0]   hit_reg, hit_next;
    logic [MAX_LINES-1:0]   rise_reg, rise_next;
    logic [MAX_LINES-1:0]   level_reg, level_next;
    logic [TIME_W-1:0]      time_reg, time_next;
    logic [1:0]             status_reg, status_next;
    sample_t                out_reg, out_next;
    logic [CNT_W-1:0]       pushed_reg, pushed_next;

    logic [CNT_W-1:0]       n_lines;
    logic [IW:0]            fill;
    logic                   full;
    lane_res_t              lane_res [MAX_LINES];

    logic                   mem_we;
    logic                   mem_re;
    sample_t                mem_wdata;
    sample_t                mem_rdata;

    assign n_lines = (line_count_reg > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES)
                                                          : line_count_reg;
    assign fill = (w_reg >= r_reg) ? {1'b0, w_reg} - {1'b0, r_reg}
                                   : {1'b0, w_reg} + (IW+1)'(2 * RING_DEPTH) - {1'b0, r_reg};
    assign full = (fill == (IW+1)'(RING_DEPTH));

    for (genvar g = 0; g < MAX_LINES; g++)
    begin : g_lane
        geec_lane u_lane (
            .pin         (line_pins_reg[g*PIN_W +: PIN_W]),
            .line_id     (line_ids_reg[g*ID_W +: ID_W]),
            .trig        (line_triggers_reg[g*TRIG_W +: TRIG_W]),
            .armed       (armed_reg[g]),
            .in_use      (CNT_W'(g) < n_lines),
            .pin_pending (pin_pending),
            .pin_levels  (pin_levels),
            .target_line (target_line),
            .res         (lane_res[g])
        );
    end

    geec_ring #(
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_of(w_reg)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (slot_of(r_reg)),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        logic found;
        state_next  = state_reg;
        w_next      = w_reg;
        r_next      = r_reg;
        drop_next   = drop_reg;
        armed_next  = armed_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        rise_next   = rise_reg;
        level_next  = level_reg;
        time_next   = time_reg;
        status_next = status_reg;
        out_next    = out_reg;
        pushed_next = pushed_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = '0;
        found       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    out_next    = '0;
                    pushed_next = '0;
                    case (func)
                        FUNC_EVENT:
                        begin
                            for (int i = 0; i < MAX_LINES; i++)
                            begin
                                hit_next[i]   = lane_res[i].hit;
                                rise_next[i]  = lane_res[i].rise;
                                level_next[i] = lane_res[i].level;
                            end
                            time_next  = event_time;
                            state_next = S_PUSH;
                        end
                        FUNC_POP:
                        begin
                            if (n_lines == '0)
                            begin
                                status_next = ST_NOT_CONFIG;
                                done_next   = 1'b1;
                            end
                            else if (w_reg == r_reg)
                            begin
                                status_next = ST_EMPTY;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                r_next     = step_idx(r_reg);
                                state_next = S_READ;
                            end
                        end
                        FUNC_ENABLE:
                        begin
                            done_next = 1'b1;
                            if (n_lines == '0)
                            begin
                                status_next = ST_NOT_CONFIG;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                                // lowest matching line wins
                                for (int i = 0; i < MAX_LINES; i++)
                                begin
                                    if (!found && lane_res[i].id_hit)
                                    begin
                                        found         = 1'b1;
                                        armed_next[i] = arm_flag;
                                        status_next   = ST_OK;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                if (hit_reg == '0)
                begin
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // take the lowest pending lane this cycle
                    for (int i = 0; i < MAX_LINES; i++)
                    begin
                        if (!found && hit_reg[i])
                        begin
                            found             = 1'b1;
                            hit_next[i]       = 1'b0;
                            mem_wdata.line_id = line_ids_reg[i*ID_W +: ID_W];
                            mem_wdata.rise    = rise_reg[i];
                            mem_wdata.level   = level_reg[i];
                            mem_wdata.stamp   = time_reg;
                        end
                    end
                    if (full)
                    begin
                        drop_next = drop_reg + 32'd1;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        w_next      = step_idx(w_reg);
                        pushed_next = pushed_reg + CNT_W'(1);
                    end
                end
            end
            S_READ:
            begin
                out_next    = mem_rdata;
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            w_reg             <= '0;
            r_reg             <= '0;
            drop_reg          <= '0;
            armed_reg         <= '0;
            done_reg          <= 1'b0;
            line_pins_reg     <= '0;
            line_ids_reg      <= '0;
            line_triggers_reg <= '0;
            line_count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
            r_reg     <= r_next;
            drop_reg  <= drop_next;
            armed_reg <= armed_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_LINE_PINS:     line_pins_reg     <= cfg_wdata[MAX_LINES*PIN_W-1:0];
                    CFG_LINE_IDS:      line_ids_reg      <= cfg_wdata[MAX_LINES*ID_W-1:0];
                    CFG_LINE_TRIGGERS: line_triggers_reg <= cfg_wdata[MAX_LINES*TRIG_W-1:0];
                    CFG_LINE_COUNT:    line_count_reg    <= cfg_wdata[CNT_W-1:0];
                    default:           line_count_reg    <= line_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        rise_reg   <= rise_next;
        level_reg  <= level_next;
        time_reg   <= time_next;
        status_reg <= status_next;
        out_reg    <= out_next;
        pushed_reg <= pushed_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign op_status      = status_reg;
    assign out_line_id    = out_reg.line_id;
    assign out_edge       = out_reg.rise;
    assign out_level      = out_reg.level;
    assign out_time       = out_reg.stamp;
    assign pushed_count   = pushed_reg;
    assign dropped_total  = drop_reg;
    assign ring_not_empty = (w_reg != r_reg);

    `GEEC_ASSERT_IMP(a_done_idle, done_reg, state_reg == S_IDLE)
    `GEEC_ASSERT_IMP(a_fill_bound, 1'b1, fill <= (IW+1)'(RING_DEPTH))
    `GEEC_ASSERT_NXT(a_accept_moves, start && !busy, busy || done)
    `GEEC_ASSERT_IMP(a_read_advanced, state_reg == S_READ, r_reg != $past(r_reg))

endmodule
